// File: rtl/core/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Types and codes shared by the in-order message resequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsq_pkg;

  localparam int unsigned IdBits  = 31;
  localparam int unsigned PayBits = 32;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_OBSOLETE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_HELD      = 3'd3,
    ST_BEYOND    = 3'd4
  } rsq_status_e;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'b001,
    FSM_EVAL  = 3'b010,
    FSM_DRAIN = 3'b100
  } rsq_fsm_e;

  typedef struct packed {
    logic [IdBits-1:0]  message_id;
    logic [PayBits-1:0] payload;
  } rsq_in_t;

  typedef struct packed {
    rsq_status_e        status;
    logic [IdBits-1:0]  out_id;
    logic [PayBits-1:0] out_payload;
    logic               last_of_run;
  } rsq_out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } rsq_cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rsq_cell.sv
// ----------------------------------------------------------------------------
// rsq_cell
// One window position: holds a message for a fixed distance past the last
// delivered id and takes its upper neighbor's contents when the window moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rsq_cell #(
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  rsq_pkg::rsq_cell_ctrl_t   ctrl_i,
  input  wire [PAYLOAD_BITS-1:0]    load_pay_i,
  input  wire                       nb_valid_i,
  input  wire [PAYLOAD_BITS-1:0]    nb_pay_i,
  output logic                      valid_o,
  output logic [PAYLOAD_BITS-1:0]   pay_o
);

  logic                    valid_d, valid_q;
  logic [PAYLOAD_BITS-1:0] pay_d, pay_q;

  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    if (ctrl_i.shift) begin
      valid_d = nb_valid_i;
      pay_d   = nb_pay_i;
    end else if (ctrl_i.load) begin
      valid_d = 1'b1;
      pay_d   = load_pay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign valid_o = valid_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

// File: rtl/core/in_order_message_resequencer.sv
// ----------------------------------------------------------------------------
// in_order_message_resequencer
// Reorders numbered messages: drops obsolete, duplicate and out-of-window
// ids, holds early ones in a shifting row of window cells, releases runs.
// ----------------------------------------------------------------------------
// Result path: input captured in in_q, evaluated, result registered in out_q.
// Inputs: a new input is taken only in the idle step, after the last one and
//   its released run are out; the cell row moves one position per release.
// Output stall holds the block in its evaluate or release step.
// Reset: control and cell valid bits cleared, last delivered id set to -1.
// ----------------------------------------------------------------------------
`default_nettype none

module in_order_message_resequencer #(
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  rsq_pkg::rsq_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output rsq_pkg::rsq_out_t  out_data_o
);

  localparam int unsigned IdxW = $clog2(WINDOW);

  rsq_pkg::rsq_fsm_e state_d, state_q;
  rsq_pkg::rsq_in_t  in_q;
  rsq_pkg::rsq_out_t res, out_q;
  logic              out_valid_q;
  logic [31:0]       ld_d, ld_q;

  logic [WINDOW:0]           valid_ext;
  logic [WINDOW-1:0]         win_valid;
  logic [PAYLOAD_BITS-1:0]   pay_ext [WINDOW+1];
  logic [PAYLOAD_BITS-1:0]   in_pay;

  logic                in_acc, out_free, emit;
  logic signed [32:0]  diff;
  logic [IdxW-1:0]     offset;
  logic                obsolete, beyond, dup;
  logic                do_shift, do_load;
  logic [30:0]         drain_id;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_pay   = PAYLOAD_BITS'(in_q.payload);
  assign drain_id = ld_q[30:0] + 31'd1;

  assign win_valid = valid_ext[WINDOW-1:0];
  assign diff      = $signed({2'b00, in_q.message_id}) - $signed({ld_q[31], ld_q});
  assign obsolete  = diff[32] || (diff == 33'sd0);
  assign beyond    = !obsolete && (diff > $signed(33'(WINDOW)));
  assign offset    = IdxW'(diff - 33'sd1);
  assign dup       = !obsolete && !beyond && win_valid[offset];

  always_comb begin
    state_d     = state_q;
    ld_d        = ld_q;
    do_shift    = 1'b0;
    do_load     = 1'b0;
    emit        = 1'b0;
    res.status      = rsq_pkg::ST_HELD;
    res.out_id      = in_q.message_id;
    res.out_payload = '0;
    res.last_of_run = 1'b1;
    case (state_q)
      rsq_pkg::FSM_IDLE: begin
        if (in_acc) begin
          state_d = rsq_pkg::FSM_EVAL;
        end
      end
      rsq_pkg::FSM_EVAL: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = rsq_pkg::FSM_IDLE;
          if (obsolete) begin
            res.status = rsq_pkg::ST_OBSOLETE;
          end else if (beyond) begin
            res.status = rsq_pkg::ST_BEYOND;
          end else if (dup) begin
            res.status = rsq_pkg::ST_DUPLICATE;
          end else if (offset != '0) begin
            res.status = rsq_pkg::ST_HELD;
            do_load    = 1'b1;
          end else begin
            res.status      = rsq_pkg::ST_DELIVERED;
            res.out_payload = 32'(in_pay);
            res.last_of_run = !valid_ext[1] || (in_q.message_id == '1);
            do_shift        = 1'b1;
            ld_d            = {1'b0, in_q.message_id};
            if (!res.last_of_run) begin
              state_d = rsq_pkg::FSM_DRAIN;
            end
          end
        end
      end
      rsq_pkg::FSM_DRAIN: begin
        if (out_free) begin
          emit            = 1'b1;
          do_shift        = 1'b1;
          res.status      = rsq_pkg::ST_DELIVERED;
          res.out_id      = drain_id;
          res.out_payload = 32'(pay_ext[0]);
          res.last_of_run = !valid_ext[1] || (drain_id == '1);
          ld_d            = {1'b0, drain_id};
          if (res.last_of_run) begin
            state_d = rsq_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = rsq_pkg::FSM_IDLE;
      end
    endcase
  end

  assign valid_ext[WINDOW] = 1'b0;
  assign pay_ext[WINDOW]   = '0;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    rsq_pkg::rsq_cell_ctrl_t ctrl;
    assign ctrl.shift = do_shift;
    assign ctrl.load  = do_load && (offset == IdxW'(k));
    rsq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_pay_i (in_pay),
      .nb_valid_i (valid_ext[k+1]),
      .nb_pay_i   (pay_ext[k+1]),
      .valid_o    (valid_ext[k]),
      .pay_o      (pay_ext[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsq_pkg::FSM_IDLE;
      ld_q        <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ld_q    <= ld_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = (state_q != rsq_pkg::FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_drain_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rsq_pkg::FSM_DRAIN |-> valid_ext[0])
    else $error("release step without a held head message");

  a_idle_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rsq_pkg::FSM_IDLE |-> !valid_ext[0])
    else $error("next in-order message left held while idle");

  a_delivery_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.status == rsq_pkg::ST_DELIVERED) |=> ld_q == $past(ld_q) + 32'd1)
    else $error("delivery did not advance the last delivered id by one");
`endif

endmodule

`default_nettype wire
